>>> rtl/core/mcpg_pkg.sv
// shared types and constants of the midpoint circle point generator
// no dependencies; imported by every module of the block
package mcpg_pkg;

	// default width of the radius and of the stored point coordinates
	localparam int RADIUS_BITS_DEF = 10;

	// default depth of the step queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// input item kinds
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	// configuration port
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic [APB_ADDR_BITS-1:0] ADDR_FILL_MODE = 3'd0;

	// status of the step queue as seen by the input handshake and the back part
	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

endpackage

>>> rtl/core/mcpg_queue.sv
// short step queue between the front and the back part
// depends on mcpg_pkg for the status struct and the default depth
module mcpg_queue
	import mcpg_pkg::*;
#(
	parameter int WIDTH = 21,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output q_status_t        status
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign status.full  = (count_q == CNT_FULL);
	assign status.valid = (count_q != '0);
	assign head_data    = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/mcpg_front.sv
// front part: accepts start and step transactions, runs the midpoint decision
// update and queues the point of each step; depends on mcpg_pkg
module mcpg_front
	import mcpg_pkg::*;
#(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fill_mode,
	input  logic                   accept,
	input  logic                   mode,
	input  logic [RADIUS_BITS-1:0] radius,
	output logic                   push,
	output logic [2*RADIUS_BITS:0] push_data
);

	localparam int DW = RADIUS_BITS + 3;

	logic [RADIUS_BITS-1:0] cur_x_q;
	logic [RADIUS_BITS-1:0] cur_y_q;
	logic signed [DW-1:0]   decision_q;
	logic [RADIUS_BITS-1:0] cur_radius_q;
	logic                   repeat_pass_q;
	logic                   active_q;

	logic [RADIUS_BITS-1:0] x_nxt;
	logic [RADIUS_BITS-1:0] y_nxt;
	logic signed [DW-1:0]   dec_nxt;
	logic signed [DW-1:0]   dec_inc;
	logic                   circle_end;
	logic                   figure_end;
	logic [RADIUS_BITS-1:0] restart_r;

	// midpoint step
	always_comb begin
		x_nxt = cur_x_q + 1'b1;
		if (decision_q[DW-1]) begin
			y_nxt   = cur_y_q;
			dec_inc = signed'({2'b00, x_nxt, 1'b1});
		end else begin
			y_nxt   = cur_y_q - 1'b1;
			dec_inc = ((signed'(DW'(x_nxt)) - signed'(DW'(y_nxt))) <<< 1) + DW'(1);
		end
		dec_nxt    = decision_q + dec_inc;
		circle_end = (y_nxt <= x_nxt);
		figure_end = circle_end && repeat_pass_q
			&& !(fill_mode && (cur_radius_q > RADIUS_BITS'(1)));
		restart_r  = repeat_pass_q ? cur_radius_q - 1'b1 : cur_radius_q;
	end

	assign push      = accept && (mode == MODE_STEP) && active_q;
	assign push_data = {figure_end, cur_x_q, cur_y_q};

	// figure state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			decision_q    <= '0;
			cur_radius_q  <= '0;
			repeat_pass_q <= 1'b0;
			active_q      <= 1'b0;
		end else if (accept && (mode == MODE_START)) begin
			cur_radius_q  <= radius;
			cur_x_q       <= '0;
			cur_y_q       <= radius;
			decision_q    <= DW'(1) - signed'(DW'(radius));
			repeat_pass_q <= 1'b1;
			active_q      <= (radius != '0);
		end else if (push) begin
			if (!circle_end) begin
				cur_x_q    <= x_nxt;
				cur_y_q    <= y_nxt;
				decision_q <= dec_nxt;
			end else if (figure_end) begin
				cur_x_q    <= x_nxt;
				cur_y_q    <= y_nxt;
				decision_q <= dec_nxt;
				active_q   <= 1'b0;
			end else begin
				// next circle: same radius again, or the next smaller one
				cur_radius_q  <= restart_r;
				cur_x_q       <= '0;
				cur_y_q       <= restart_r;
				decision_q    <= DW'(1) - signed'(DW'(restart_r));
				repeat_pass_q <= !repeat_pass_q;
			end
		end
	end

endmodule

>>> rtl/core/mcpg_back.sv
// back part: takes one queued step and emits its eight octant points through
// a registered output; depends on mcpg_pkg
module mcpg_back
	import mcpg_pkg::*;
#(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  q_status_t                     q_status,
	input  logic [2*RADIUS_BITS:0]        head_data,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [RADIUS_BITS:0]   offset_x,
	output logic signed [RADIUS_BITS:0]   offset_y,
	output logic                          last,
	output logic                          figure_done
);

	localparam logic [2:0] PT_LAST = 3'd7;

	logic [RADIUS_BITS-1:0] ent_x_q;
	logic [RADIUS_BITS-1:0] ent_y_q;
	logic                   ent_done_q;
	logic                   have_q;
	logic [2:0]             pt_q;
	logic                   out_valid_q;

	logic                   adv;
	logic signed [RADIUS_BITS:0] xs;
	logic signed [RADIUS_BITS:0] ys;
	logic signed [RADIUS_BITS:0] px;
	logic signed [RADIUS_BITS:0] py;

	assign adv       = have_q && (!out_valid_q || !out_stall);
	assign pop       = q_status.valid && (!have_q || (adv && (pt_q == PT_LAST)));
	assign out_valid = out_valid_q;

	// octant point select
	always_comb begin
		xs = signed'({1'b0, ent_x_q});
		ys = signed'({1'b0, ent_y_q});
		case (pt_q)
			3'd0: begin px = ys;  py = xs;  end
			3'd1: begin px = xs;  py = ys;  end
			3'd2: begin px = -xs; py = ys;  end
			3'd3: begin px = -ys; py = xs;  end
			3'd4: begin px = -ys; py = -xs; end
			3'd5: begin px = -xs; py = -ys; end
			3'd6: begin px = xs;  py = -ys; end
			default: begin px = ys; py = -xs; end
		endcase
	end

	// current step entry
	always_ff @(posedge clk) begin
		if (pop) begin
			{ent_done_q, ent_x_q, ent_y_q} <= head_data;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv) begin
			offset_x    <= px;
			offset_y    <= py;
			last        <= (pt_q == PT_LAST);
			figure_done <= (pt_q == PT_LAST) && ent_done_q;
		end
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			pt_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				pt_q        <= pt_q + 1'b1;
				if (pt_q == PT_LAST) begin
					have_q <= 1'b0;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				have_q <= 1'b1;
				pt_q   <= '0;
			end
		end
	end

endmodule

>>> rtl/core/midpoint_circle_point_generator_unit.sv
// top level of the midpoint circle point generator: register port, front,
// step queue and back; depends on mcpg_pkg, mcpg_front, mcpg_queue, mcpg_back
//
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  mode, radius
// out      output     out_valid/out_stall offset_x, offset_y, last, figure_done
// apb      input      psel/penable/pready paddr, pwrite, pwdata, prdata
//
// a start transaction is taken while in_stall is low and emits nothing
// a step transaction is taken while in_stall is low; its eight points leave through the
// output register at one point per cycle while out_stall is low
// in_stall rises only when the step queue is full; out_stall holds the output
// reset clears the figure state, the queue and fill_mode to 1
module midpoint_circle_point_generator_unit
	import mcpg_pkg::*;
#(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic [RADIUS_BITS-1:0]     radius,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [RADIUS_BITS:0] offset_x,
	output logic signed [RADIUS_BITS:0] offset_y,
	output logic                       last,
	output logic                       figure_done,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [APB_ADDR_BITS-1:0]   paddr,
	input  logic [APB_DATA_BITS-1:0]   pwdata,
	output logic [APB_DATA_BITS-1:0]   prdata,
	output logic                       pready
);

	localparam int QW = 2 * RADIUS_BITS + 1;

	logic           fill_mode_q;
	logic           cfg_wr;
	logic           in_accept;
	logic           q_push;
	logic           q_pop;
	logic [QW-1:0]  q_push_data;
	logic [QW-1:0]  q_head_data;
	q_status_t      q_status;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[APB_ADDR_BITS-1:2] == ADDR_FILL_MODE[APB_ADDR_BITS-1:2])
		? APB_DATA_BITS'(fill_mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_mode_q <= 1'b1;
		end else if (cfg_wr
			&& (paddr[APB_ADDR_BITS-1:2] == ADDR_FILL_MODE[APB_ADDR_BITS-1:2])) begin
			fill_mode_q <= pwdata[0];
		end
	end

	// input handshake
	assign in_stall  = q_status.full;
	assign in_accept = in_valid && !in_stall;

	mcpg_front #(
		.RADIUS_BITS (RADIUS_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.fill_mode (fill_mode_q),
		.accept    (in_accept),
		.mode      (mode),
		.radius    (radius),
		.push      (q_push),
		.push_data (q_push_data)
	);

	mcpg_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head_data (q_head_data),
		.status    (q_status)
	);

	mcpg_back #(
		.RADIUS_BITS (RADIUS_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.head_data   (q_head_data),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.offset_x    (offset_x),
		.offset_y    (offset_y),
		.last        (last),
		.figure_done (figure_done)
	);

`ifndef SYNTHESIS
	// no step is queued while the queue is full
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("step queued into full queue");

	// the back part only pops a queue that holds a step
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_status.valid)
		else $error("pop from empty queue");

	// the end of a figure is marked only on the eighth point
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && figure_done) |-> last)
		else $error("figure_done without last");
`endif

endmodule
